[rtl/touch_map_and_button_hit_test_macros.svh]
// Assertion macros for the touch mapping and button hit test block.
// Included by the checker; needs clk and rst in the including scope.
`ifndef TOUCH_MAP_AND_BUTTON_HIT_TEST_MACROS_SVH
`define TOUCH_MAP_AND_BUTTON_HIT_TEST_MACROS_SVH

// Property that must hold in the same cycle.
`define TMBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define TMBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/tmbh_pkg.sv]
// Package for the touch mapping and button hit test block.
// Holds constants, register codes, control states and the token type; no dependencies.
`timescale 1ns / 1ps

package tmbh_pkg;

  localparam int RAW_X_LO = 120;
  localparam int RAW_X_HI = 900;
  localparam int RAW_Y_LO = 70;
  localparam int RAW_Y_HI = 920;
  localparam int PRESS_LO = 10;
  localparam int PRESS_HI = 1000;

  localparam int RAW_X_SPAN = RAW_X_HI - RAW_X_LO;
  localparam int RAW_Y_SPAN = RAW_Y_HI - RAW_Y_LO;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_X = (1 << RECIP_SHIFT) / RAW_X_SPAN;
  localparam int RECIP_Y = (1 << RECIP_SHIFT) / RAW_Y_SPAN;

  localparam logic [1:0] CFG_ROTATION = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_HEIGHT   = 2'd2;

  localparam logic [1:0] ROT_NORMAL     = 2'd0;
  localparam logic [1:0] ROT_UPSIDE     = 2'd1;
  localparam logic [1:0] ROT_SIDE_RIGHT = 2'd2;
  localparam logic [1:0] ROT_SIDE_LEFT  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_t;

  // Word travelling along the row of button cells.
  typedef struct packed {
    logic               vld;
    logic               add;
    logic               touch;
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic               hit;
    logic [2:0]         idx;
    logic [9:0]         left;
    logic [9:0]         top;
    logic [10:0]        right;
    logic [10:0]        bottom;
    logic               action;
    logic               placed;
  } tmbh_token_t;

endpackage

[rtl/touch_map_and_button_hit_test.sv]
// Touch mapping and button hit test: maps a raw touch to screen pixels, then runs
// the word along a row of MAX_BUTTONS button cells, one cell per cycle.
// A word passes the mapping, then the cells, then a result register and the output registers.
// A new word is taken only once the result of the last one has been loaded to the output.
// Reset (synchronous, active high) empties the button table and restores the
// registers to rotation 0, width 240, height 320.
`timescale 1ns / 1ps

module touch_map_and_button_hit_test #(
  parameter int MAX_BUTTONS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [9:0]         raw_x,
  input  logic [9:0]         raw_y,
  input  logic [9:0]         pressure,
  input  logic [9:0]         box_left,
  input  logic [9:0]         box_top,
  input  logic [9:0]         box_width,
  input  logic [9:0]         box_height,
  input  logic               has_action,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               press_valid,
  output logic               hit,
  output logic [2:0]         hit_index,
  output logic signed [11:0] screen_x,
  output logic signed [11:0] screen_y,
  output logic               table_full
);
  import tmbh_pkg::*;

  logic [1:0]  rotation_mode;
  logic [9:0]  screen_width;
  logic [9:0]  screen_height;

  state_t      state, state_next;
  logic        accept;
  logic        load;
  logic        item_add;
  logic        item_touch;
  logic [9:0]  item_left;
  logic [9:0]  item_top;
  logic [10:0] item_right;
  logic [10:0] item_bottom;
  logic        item_action;

  logic               map_done;
  logic signed [11:0] map_sx;
  logic signed [11:0] map_sy;

  tmbh_token_t chain [MAX_BUTTONS + 1];
  tmbh_token_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_mode <= ROT_NORMAL;
      screen_width  <= 10'd240;
      screen_height <= 10'd320;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROTATION: rotation_mode <= cfg_data[1:0];
        CFG_WIDTH:    screen_width  <= cfg_data;
        CFG_HEIGHT:   screen_height <= cfg_data;
        default:      ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_add    <= opcode;
      item_touch  <= !opcode && (pressure > 10'(PRESS_LO)) && (pressure < 10'(PRESS_HI));
      item_left   <= box_left;
      item_top    <= box_top;
      item_right  <= {1'b0, box_left} + {1'b0, box_width};
      item_bottom <= {1'b0, box_top} + {1'b0, box_height};
      item_action <= has_action;
    end
  end

  tmbh_map u_map (
    .clk           (clk),
    .rst           (rst),
    .start         (accept),
    .raw_x         (raw_x),
    .raw_y         (raw_y),
    .rotation_mode (rotation_mode),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .done          (map_done),
    .sx            (map_sx),
    .sy            (map_sy)
  );

  always_comb begin
    chain[0].vld    = map_done;
    chain[0].add    = item_add;
    chain[0].touch  = item_touch;
    chain[0].sx     = item_touch ? map_sx : 12'sd0;
    chain[0].sy     = item_touch ? map_sy : 12'sd0;
    chain[0].hit    = 1'b0;
    chain[0].idx    = 3'd0;
    chain[0].left   = item_left;
    chain[0].top    = item_top;
    chain[0].right  = item_right;
    chain[0].bottom = item_bottom;
    chain[0].action = item_action;
    chain[0].placed = 1'b0;
  end

  for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_cell
    tmbh_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .slot    (3'(i)),
      .tok_in  (chain[i]),
      .tok_out (chain[i + 1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (chain[MAX_BUTTONS].vld) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (chain[MAX_BUTTONS].vld) begin
      res <= chain[MAX_BUTTONS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      press_valid <= res.touch;
      hit         <= res.hit;
      hit_index   <= res.hit ? res.idx : 3'd0;
      screen_x    <= res.sx;
      screen_y    <= res.sy;
      table_full  <= res.add && !res.placed;
    end
  end

endmodule

[rtl/tmbh_map.sv]
// Raw panel to screen coordinate mapping, two lanes of a five stage pipeline.
// Division by the constant raw spans uses a reciprocal multiply and one correction.
// Depends on tmbh_pkg.
`timescale 1ns / 1ps

module tmbh_map (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [9:0]         raw_x,
  input  logic [9:0]         raw_y,
  input  logic [1:0]         rotation_mode,
  input  logic [9:0]         screen_width,
  input  logic [9:0]         screen_height,
  output logic               done,
  output logic signed [11:0] sx,
  output logic signed [11:0] sy
);
  import tmbh_pkg::*;

  logic [4:0]         vld;
  logic signed [11:0] coord [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    localparam int Lo    = (l == 0) ? RAW_X_LO : RAW_Y_LO;
    localparam int Span  = (l == 0) ? RAW_X_SPAN : RAW_Y_SPAN;
    localparam int Recip = (l == 0) ? RECIP_X : RECIP_Y;

    logic [9:0]  raw_l;
    logic [10:0] diff;
    logic [9:0]  scale;
    logic        rev;
    logic [9:0]  mag1, scale1, from1, from2, from3, from4;
    logic        neg1, neg2, neg3, neg4;
    logic [19:0] prod2, prod3;
    logic [40:0] recip_prod;
    logic [10:0] q0_3, q4;
    logic [20:0] rem;

    assign raw_l = (l == 0) ? raw_x : raw_y;
    assign diff  = {1'b0, raw_l} - 11'(Lo);

    always_comb begin
      if (l == 0) begin
        scale = rotation_mode[1] ? screen_height : screen_width;
        rev   = (rotation_mode == ROT_UPSIDE) || (rotation_mode == ROT_SIDE_RIGHT);
      end else begin
        scale = rotation_mode[1] ? screen_width : screen_height;
        rev   = (rotation_mode == ROT_NORMAL) || (rotation_mode == ROT_SIDE_RIGHT);
      end
    end

    assign recip_prod = 41'(prod2) * 41'(Recip);
    assign rem        = 21'(prod3) - 21'(q0_3) * 21'(Span);

    always_ff @(posedge clk) begin
      mag1   <= diff[10] ? 10'(-diff) : diff[9:0];
      scale1 <= scale;
      from1  <= rev ? scale : 10'd0;
      neg1   <= diff[10] ^ rev;

      prod2 <= 20'(mag1) * 20'(scale1);
      from2 <= from1;
      neg2  <= neg1;

      q0_3  <= recip_prod[40:30];
      prod3 <= prod2;
      from3 <= from2;
      neg3  <= neg2;

      q4    <= q0_3 + 11'(rem >= 21'(Span));
      from4 <= from3;
      neg4  <= neg3;

      coord[l] <= neg4 ? $signed({2'b00, from4} - {1'b0, q4})
                       : $signed({2'b00, from4} + {1'b0, q4});
    end
  end

  assign done = vld[4];
  assign sx   = rotation_mode[1] ? coord[1] : coord[0];
  assign sy   = rotation_mode[1] ? coord[0] : coord[1];

endmodule

[rtl/tmbh_cell.sv]
// One button slot of the table; stores a rectangle and passes the word on each cycle.
// Places an add word in the first free slot and flags the first hit of a touch word.
// Depends on tmbh_pkg.
`timescale 1ns / 1ps

module tmbh_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [2:0]           slot,
  input  tmbh_pkg::tmbh_token_t tok_in,
  output tmbh_pkg::tmbh_token_t tok_out
);
  import tmbh_pkg::*;

  logic        occupied;
  logic [9:0]  left;
  logic [9:0]  top;
  logic [10:0] right;
  logic [10:0] bottom;
  logic        action;
  logic        place;
  logic        match;
  logic        inside_x;
  logic        inside_y;
  tmbh_token_t tok_next;

  assign inside_x = !tok_in.sx[11] && (tok_in.sx[10:0] >= {1'b0, left}) &&
                    (tok_in.sx[10:0] <= right);
  assign inside_y = !tok_in.sy[11] && (tok_in.sy[10:0] >= {1'b0, top}) &&
                    (tok_in.sy[10:0] <= bottom);

  always_comb begin
    place    = tok_in.vld && tok_in.add && !tok_in.placed && !occupied;
    match    = tok_in.vld && tok_in.touch && !tok_in.hit && occupied && action &&
               inside_x && inside_y;
    tok_next = tok_in;
    if (place) begin
      tok_next.placed = 1'b1;
    end
    if (match) begin
      tok_next.hit = 1'b1;
      tok_next.idx = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied    <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      occupied <= occupied | place;
      tok_out  <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (place) begin
      left   <= tok_in.left;
      top    <= tok_in.top;
      right  <= tok_in.right;
      bottom <= tok_in.bottom;
      action <= tok_in.action;
    end
  end

endmodule

[rtl/tmbh_checker.sv]
// Port level checker for the touch mapping and button hit test block, bound to the top.
// Depends on touch_map_and_button_hit_test_macros.svh.
`timescale 1ns / 1ps
`include "touch_map_and_button_hit_test_macros.svh"

module tmbh_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               press_valid,
  input logic               hit,
  input logic [2:0]         hit_index,
  input logic signed [11:0] screen_x,
  input logic signed [11:0] screen_y,
  input logic               table_full
);

  `TMBH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit) && $stable(hit_index) && $stable(screen_x) && $stable(screen_y), "stalled result word changed")
  `TMBH_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second word taken while busy")
  `TMBH_ASSERT(a_hit_needs_press, !(out_valid && hit && !press_valid), "hit without valid pressure")
  `TMBH_ASSERT(a_full_is_add, !(out_valid && table_full && (press_valid || hit || screen_x != 12'sd0 || screen_y != 12'sd0)), "full flag on a touch result")
  `TMBH_ASSERT(a_index_zero, !(out_valid && !hit && hit_index != 3'd0), "index set without a hit")

endmodule

bind touch_map_and_button_hit_test tmbh_checker u_tmbh_checker (.*);

[verif/touch_map_and_button_hit_test_tb.sv]
// Self-checking testbench for the touch mapping and button hit test block.
// A directed table, then random words; rows without fixed results use an in-bench predictor.
// Depends on tmbh_pkg and touch_map_and_button_hit_test.
`timescale 1ns / 1ps

module touch_map_and_button_hit_test_tb;
  import tmbh_pkg::*;

  localparam int MAX_BUTTONS = 8;
  localparam int STALL_LIMIT = 2000;
  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_ADD   = 1'b1;

  typedef struct packed {
    logic       op;
    logic [9:0] rx;
    logic [9:0] ry;
    logic [9:0] prs;
    logic [9:0] left;
    logic [9:0] top;
    logic [9:0] wid;
    logic [9:0] hgt;
    logic       act;
  } panel_word_t;

  typedef struct packed {
    logic               pv;
    logic               hit;
    logic [2:0]         idx;
    logic signed [11:0] sx;
    logic signed [11:0] sy;
    logic               full;
  } hit_result_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [9:0]  reg_val;
    panel_word_t word;
    logic        known;
    hit_result_t golden;
  } plan_row_t;

  typedef struct {
    int left;
    int top;
    int right;
    int bottom;
    bit action;
  } button_rect_t;

  localparam hit_result_t QUIET_RESULT = '0;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [9:0]         cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               opcode;
  logic [9:0]         raw_x;
  logic [9:0]         raw_y;
  logic [9:0]         pressure;
  logic [9:0]         box_left;
  logic [9:0]         box_top;
  logic [9:0]         box_width;
  logic [9:0]         box_height;
  logic               has_action;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               press_valid;
  logic               hit;
  logic [2:0]         hit_index;
  logic signed [11:0] screen_x;
  logic signed [11:0] screen_y;
  logic               table_full;

  logic [1:0]   rot_mode;
  logic [9:0]   scr_w;
  logic [9:0]   scr_h;
  button_rect_t btn_table [MAX_BUTTONS];
  int           btn_count;

  hit_result_t due_reports [$];
  plan_row_t   plan [$];
  bit          idling;
  int          mismatches;
  int          words_sent;
  int          touches_in_window;
  int          hits_predicted;
  int          adds_dropped;
  int          settings_used;
  int          results_seen;
  int          stall_left;
  int          idle_cycles;

  touch_map_and_button_hit_test #(.MAX_BUTTONS(MAX_BUTTONS)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int scale_axis(int v, int lo, int hi, int from, int to);
    return (v - lo) * (to - from) / (hi - lo) + from;
  endfunction

  function automatic hit_result_t hit_test_word(panel_word_t w);
    hit_result_t r;
    int sx;
    int sy;
    int wd;
    int ht;
    bit found;
    r = QUIET_RESULT;
    sx = 0;
    sy = 0;
    wd = scr_w;
    ht = scr_h;
    found = 1'b0;
    if (w.op == OP_ADD) begin
      if (btn_count >= MAX_BUTTONS) begin
        r.full = 1'b1;
      end else begin
        btn_table[btn_count] = '{int'(w.left), int'(w.top), int'(w.left) + int'(w.wid),
                                 int'(w.top) + int'(w.hgt), w.act};
        btn_count++;
      end
    end else if (w.prs > PRESS_LO && w.prs < PRESS_HI) begin
      r.pv = 1'b1;
      case (rot_mode)
        ROT_NORMAL: begin
          sx = scale_axis(w.rx, RAW_X_LO, RAW_X_HI, 0, wd);
          sy = scale_axis(w.ry, RAW_Y_LO, RAW_Y_HI, ht, 0);
        end
        ROT_UPSIDE: begin
          sx = scale_axis(w.rx, RAW_X_LO, RAW_X_HI, wd, 0);
          sy = scale_axis(w.ry, RAW_Y_LO, RAW_Y_HI, 0, ht);
        end
        ROT_SIDE_RIGHT: begin
          sy = scale_axis(w.rx, RAW_X_LO, RAW_X_HI, ht, 0);
          sx = scale_axis(w.ry, RAW_Y_LO, RAW_Y_HI, wd, 0);
        end
        default: begin
          sy = scale_axis(w.rx, RAW_X_LO, RAW_X_HI, 0, ht);
          sx = scale_axis(w.ry, RAW_Y_LO, RAW_Y_HI, 0, wd);
        end
      endcase
      for (int i = 0; i < btn_count; i++) begin
        if (!found && btn_table[i].action && sx >= btn_table[i].left &&
            sx <= btn_table[i].right && sy >= btn_table[i].top && sy <= btn_table[i].bottom) begin
          found = 1'b1;
          r.hit = 1'b1;
          r.idx = 3'(i);
        end
      end
      r.sx = 12'(sx);
      r.sy = 12'(sy);
    end
    return r;
  endfunction

  function automatic plan_row_t touch_row(int rx, int ry, int prs);
    plan_row_t p;
    p = '0;
    p.word.op = OP_TOUCH;
    p.word.rx = 10'(rx);
    p.word.ry = 10'(ry);
    p.word.prs = 10'(prs);
    return p;
  endfunction

  function automatic plan_row_t button_row(int l, int t, int wd, int ht, bit a);
    plan_row_t p;
    p = '0;
    p.word.op = OP_ADD;
    p.word.left = 10'(l);
    p.word.top = 10'(t);
    p.word.wid = 10'(wd);
    p.word.hgt = 10'(ht);
    p.word.act = a;
    return p;
  endfunction

  function automatic plan_row_t reg_row(logic [1:0] idx, int val);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.reg_idx = idx;
    p.reg_val = 10'(val);
    return p;
  endfunction

  function automatic plan_row_t with_known(plan_row_t p, hit_result_t g);
    p.known = 1'b1;
    p.golden = g;
    return p;
  endfunction

  function automatic panel_word_t random_word();
    panel_word_t w;
    int pick;
    w = panel_word_t'({$urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    w.op = (pick < 6) ? OP_ADD : OP_TOUCH;
    if (w.op == OP_ADD) begin
      if ($urandom_range(0, 4) != 0) begin
        w.left = 10'($urandom_range(0, 400));
        w.top = 10'($urandom_range(0, 500));
        w.wid = 10'($urandom_range(0, 250));
        w.hgt = 10'($urandom_range(0, 250));
      end
      w.act = ($urandom_range(0, 3) != 0);
    end else if (pick < 90) begin
      w.rx = 10'($urandom_range(100, 920));
      w.ry = 10'($urandom_range(50, 940));
      w.prs = 10'($urandom_range(PRESS_LO + 1, PRESS_HI - 1));
    end else begin
      case ($urandom_range(0, 4))
        0: w.prs = 10'(PRESS_LO);
        1: w.prs = 10'(PRESS_LO + 1);
        2: w.prs = 10'(PRESS_HI - 1);
        3: w.prs = 10'(PRESS_HI);
        default: w.prs = 10'($urandom_range(0, 1023));
      endcase
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR: %s is %0d, expected %0d (at %0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_word(panel_word_t w, bit use_known, hit_result_t known_res);
    hit_result_t r;
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= w.op;
    raw_x <= w.rx;
    raw_y <= w.ry;
    pressure <= w.prs;
    box_left <= w.left;
    box_top <= w.top;
    box_width <= w.wid;
    box_height <= w.hgt;
    has_action <= w.act;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    r = hit_test_word(w);
    due_reports.push_back(use_known ? known_res : r);
    words_sent++;
    touches_in_window += r.pv;
    hits_predicted += r.hit;
    adds_dropped += r.full;
  endtask

  task automatic drain(int tail);
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROTATION: rot_mode = val[1:0];
      CFG_WIDTH:    scr_w = val;
      CFG_HEIGHT:   scr_h = val;
      default: ;
    endcase
    settings_used++;
  endtask

  always @(posedge clk) begin
    if (rst || !idling) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(negedge clk) begin : check_results
    hit_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (due_reports.size() == 0) begin
        report_mismatch("unexpected result, press_valid", press_valid, 0);
      end else begin
        want = due_reports.pop_front();
        if (press_valid !== want.pv) report_mismatch("press_valid", press_valid, want.pv);
        if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
        if (hit_index !== want.idx) report_mismatch("hit_index", hit_index, want.idx);
        if (screen_x !== want.sx) report_mismatch("screen_x", screen_x, want.sx);
        if (screen_y !== want.sy) report_mismatch("screen_y", screen_y, want.sy);
        if (table_full !== want.full) report_mismatch("table_full", table_full, want.full);
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : main
    int w_cfg;
    int h_cfg;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_ROTATION;
    cfg_data = '0;
    in_valid = 1'b0;
    opcode = OP_TOUCH;
    raw_x = '0;
    raw_y = '0;
    pressure = '0;
    box_left = '0;
    box_top = '0;
    box_width = '0;
    box_height = '0;
    has_action = 1'b0;
    idling = 1'b1;
    rot_mode = ROT_NORMAL;
    scr_w = 10'd240;
    scr_h = 10'd320;
    btn_count = 0;
    foreach (btn_table[i]) btn_table[i] = '{0, 0, 0, 0, 1'b0};

    // Pressure window edges first, then the calibration corners on an empty table.
    plan.push_back(with_known(touch_row(0, 0, 0), QUIET_RESULT));
    plan.push_back(with_known(touch_row(1023, 1023, 10), QUIET_RESULT));
    plan.push_back(with_known(touch_row(512, 512, 1000), QUIET_RESULT));
    plan.push_back(with_known(touch_row(1023, 1023, 1023), QUIET_RESULT));
    plan.push_back(with_known(touch_row(120, 70, 11),
                              hit_result_t'{1'b1, 1'b0, 3'd0, 12'sd0, 12'sd320, 1'b0}));
    plan.push_back(with_known(touch_row(900, 920, 999),
                              hit_result_t'{1'b1, 1'b0, 3'd0, 12'sd240, 12'sd0, 1'b0}));
    plan.push_back(touch_row(0, 0, 500));
    plan.push_back(touch_row(1023, 1023, 500));
    // A one-pixel button, a full-screen button without action and a small corner button.
    plan.push_back(with_known(button_row(0, 320, 0, 0, 1'b1), QUIET_RESULT));
    plan.push_back(with_known(button_row(0, 0, 1023, 1023, 1'b0), QUIET_RESULT));
    plan.push_back(with_known(button_row(200, 0, 40, 10, 1'b1), QUIET_RESULT));
    plan.push_back(with_known(touch_row(120, 70, 500),
                              hit_result_t'{1'b1, 1'b1, 3'd0, 12'sd0, 12'sd320, 1'b0}));
    plan.push_back(with_known(touch_row(900, 920, 500),
                              hit_result_t'{1'b1, 1'b1, 3'd2, 12'sd240, 12'sd0, 1'b0}));
    plan.push_back(with_known(button_row(1023, 1023, 1023, 1023, 1'b1), QUIET_RESULT));
    plan.push_back(touch_row(1023, 1023, 500));
    plan.push_back(reg_row(CFG_ROTATION, ROT_UPSIDE));
    plan.push_back(touch_row(120, 70, 500));
    // A zero screen size still goes through the mapping.
    plan.push_back(reg_row(CFG_WIDTH, 0));
    plan.push_back(reg_row(CFG_HEIGHT, 0));
    plan.push_back(touch_row(512, 300, 500));
    plan.push_back(reg_row(CFG_ROTATION, ROT_SIDE_LEFT));
    plan.push_back(reg_row(CFG_WIDTH, 1023));
    plan.push_back(reg_row(CFG_HEIGHT, 1023));
    plan.push_back(touch_row(900, 920, 500));
    plan.push_back(touch_row(0, 0, 500));
    plan.push_back(reg_row(CFG_ROTATION, ROT_SIDE_RIGHT));
    plan.push_back(touch_row(0, 0, 500));
    plan.push_back(touch_row(1023, 1023, 500));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain(4);
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].word, plan[i].known, plan[i].golden);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin w_cfg = 240; h_cfg = 320; end
        1: begin w_cfg = 320; h_cfg = 240; end
        2: begin w_cfg = 1; h_cfg = 1; end
        3: begin w_cfg = 1023; h_cfg = 1023; end
        default: begin
          w_cfg = $urandom_range(1, 1023);
          h_cfg = $urandom_range(1, 1023);
        end
      endcase
      drain(4);
      write_reg(CFG_ROTATION, 10'(ph % 4));
      write_reg(CFG_WIDTH, 10'(w_cfg));
      write_reg(CFG_HEIGHT, 10'(h_cfg));
      idling = (ph % 3 != 2);
      for (int n = 0; n < 200; n++) begin
        if (ph == 7 && n == 50) idling = 1'b0;
        send_word(random_word(), 1'b0, QUIET_RESULT);
      end
    end

    drain(MAX_BUTTONS + 8);
    $display("Run covered %0d words: %0d touches in the pressure window, %0d hits, %0d adds dropped.",
             words_sent, touches_in_window, hits_predicted, adds_dropped);
    $display("All four rotations were used over %0d register writes; %0d results were checked.",
             settings_used, results_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
